// ===== rtl/first_free_slot_allocator_core_defines.svh =====
// Assertion macros used by the allocator core.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef FIRST_FREE_SLOT_ALLOCATOR_CORE_DEFINES_SVH
`define FIRST_FREE_SLOT_ALLOCATOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FFSA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FFSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ffsa_pkg.sv =====
package ffsa_pkg;

    localparam int NUM_ROOMS = 1024;
    localparam int ROOM_W    = 11;
    localparam int WORD_W    = 64;
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int DEPTH     = (NUM_ROOMS + WORD_W - 1) / WORD_W;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SLOT_W    = ADDR_W + BIT_W;

    localparam logic [ROOM_W-1:0] ROOM_COUNT_RESET = ROOM_W'(1024);
    localparam logic [ROOM_W-1:0] ROOM_LIMIT_MAX   = ROOM_W'(NUM_ROOMS);

    localparam logic STATUS_GRANTED = 1'b0;
    localparam logic STATUS_FULL    = 1'b1;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [ADDR_W-1:0] addr_t;

    typedef struct packed {
        addr_t rd_addr;
        logic  wr_en;
        addr_t wr_addr;
        word_t wr_data;
    } mem_req_t;

    // Binary position of the single set bit of a one-hot word.
    function automatic logic [BIT_W-1:0] onehot_to_bin(input word_t oh);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (oh[i])
            begin
                pos = pos | BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

// ===== rtl/first_free_slot_allocator_core.sv =====
// A request outside 1..limit is answered as full without a scan; a valid request is answered once
// its scan of k bitmap words (k from 1 to 16) finds a free slot or reaches the limit word.
// A new request is taken only in the idle state, so one at a time; the scan reads one 64-bit word a
// cycle from the occupancy memory (one read and one write port) and writes the hit word back.
// Reset: every slot free through per-word written flags (no clearing pass), room_count 1024.
`include "first_free_slot_allocator_core_defines.svh"

module first_free_slot_allocator_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [ffsa_pkg::ROOM_W-1:0]  room_count,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ffsa_pkg::ROOM_W-1:0]  requested_room,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ffsa_pkg::ROOM_W-1:0]  granted_room,
    output logic                         status
);
    import ffsa_pkg::*;

    mem_req_t mem_req;
    word_t    mem_rd_data;

    assign cfg_ready = 1'b1;

    ffsa_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_room_count (room_count),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .requested_room (requested_room),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .granted_room   (granted_room),
        .status         (status),
        .mem_req        (mem_req),
        .mem_rd_data    (mem_rd_data)
    );

    ffsa_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    // A write-back must never meet a read of the same word in one cycle.
    `FFSA_ASSERT_SAME(a_no_rw_clash, mem_req.wr_en, mem_req.rd_addr != mem_req.wr_addr, "read and write-back hit the same word")
    `FFSA_ASSERT_SAME(a_full_is_zero, out_valid && (status == STATUS_FULL), granted_room == '0, "full result carries a slot number")
    `FFSA_ASSERT_SAME(a_grant_nonzero, out_valid && (status == STATUS_GRANTED), granted_room != '0, "granted result carries slot zero")
    `FFSA_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second request taken while a scan is running")

endmodule

// ===== rtl/ffsa_mem.sv =====
module ffsa_mem (
    input  logic              clk,
    input  logic              rst_n,
    input  ffsa_pkg::mem_req_t req,
    output ffsa_pkg::word_t   rd_data
);
    import ffsa_pkg::*;

    word_t mem [DEPTH];
    logic [DEPTH-1:0] written_reg;
    logic [DEPTH-1:0] written_next;
    word_t rd_word_reg;
    logic  rd_written_reg;

    // A word never written since reset reads as all free.
    always_comb
    begin
        written_next = written_reg;
        if (req.wr_en)
        begin
            written_next[req.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            written_reg    <= written_next;
            rd_written_reg <= written_reg[req.rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_word_reg <= mem[req.rd_addr];
    end

    assign rd_data = rd_word_reg & {WORD_W{rd_written_reg}};

endmodule

// ===== rtl/ffsa_ctrl.sv =====
module ffsa_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    input  logic [ffsa_pkg::ROOM_W-1:0]  cfg_room_count,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ffsa_pkg::ROOM_W-1:0]  requested_room,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ffsa_pkg::ROOM_W-1:0]  granted_room,
    output logic                         status,
    output ffsa_pkg::mem_req_t           mem_req,
    input  ffsa_pkg::word_t              mem_rd_data
);
    import ffsa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CHECK = 3'b010,
        S_DONE  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    addr_t  scan_reg, scan_next;
    addr_t  last_reg, last_next;
    word_t  lo_mask_reg, lo_mask_next;
    word_t  hi_mask_reg, hi_mask_next;
    logic [ROOM_W-1:0] res_room_reg, res_room_next;
    logic              res_status_reg, res_status_next;
    logic              out_valid_reg, out_valid_next;
    logic [ROOM_W-1:0] out_room_reg, out_room_next;
    logic              out_status_reg, out_status_next;
    logic [ROOM_W-1:0] room_count_reg, room_count_next;

    logic [ROOM_W-1:0] limit;
    logic [ROOM_W-1:0] req_m1;
    logic [ROOM_W-1:0] lim_m1;
    logic              req_bad;
    word_t             free_bits;
    word_t             first_free;
    logic              hit;
    logic [BIT_W-1:0]  hit_pos;
    logic [ROOM_W-1:0] hit_room;
    logic              slot_free;

    always_comb
    begin
        limit   = (room_count_reg > ROOM_LIMIT_MAX) ? ROOM_LIMIT_MAX : room_count_reg;
        req_bad = (requested_room == '0) || (requested_room > limit);
        req_m1  = requested_room - ROOM_W'(1);
        lim_m1  = limit - ROOM_W'(1);

        free_bits = ~mem_rd_data & lo_mask_reg
                    & ((scan_reg == last_reg) ? hi_mask_reg : {WORD_W{1'b1}});
        hit        = |free_bits;
        first_free = free_bits & (~free_bits + word_t'(1));
        hit_pos    = onehot_to_bin(first_free);
        hit_room   = ROOM_W'({scan_reg, hit_pos}) + ROOM_W'(1);
        slot_free  = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        state_next      = state_reg;
        scan_next       = scan_reg;
        last_next       = last_reg;
        lo_mask_next    = lo_mask_reg;
        hi_mask_next    = hi_mask_reg;
        res_room_next   = res_room_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_room_next   = out_room_reg;
        out_status_next = out_status_reg;
        room_count_next = cfg_valid ? cfg_room_count : room_count_reg;

        mem_req.rd_addr = req_m1[SLOT_W-1:BIT_W];
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = scan_reg;
        mem_req.wr_data = mem_rd_data | first_free;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_bad)
                    begin
                        res_room_next   = '0;
                        res_status_next = STATUS_FULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        scan_next    = req_m1[SLOT_W-1:BIT_W];
                        last_next    = lim_m1[SLOT_W-1:BIT_W];
                        lo_mask_next = {WORD_W{1'b1}} << req_m1[BIT_W-1:0];
                        hi_mask_next = {WORD_W{1'b1}}
                                       >> (BIT_W'(WORD_W - 1) - lim_m1[BIT_W-1:0]);
                        state_next   = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                // The next word is fetched while this one is examined.
                mem_req.rd_addr = scan_reg + addr_t'(1);
                if (hit || (scan_reg == last_reg))
                begin
                    mem_req.wr_en   = hit;
                    res_room_next   = hit ? hit_room : '0;
                    res_status_next = hit ? STATUS_GRANTED : STATUS_FULL;
                    if (slot_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_room_next   = res_room_next;
                        out_status_next = res_status_next;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    scan_next    = scan_reg + addr_t'(1);
                    lo_mask_next = {WORD_W{1'b1}};
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_room_next   = res_room_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            room_count_reg <= ROOM_COUNT_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            room_count_reg <= room_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg       <= scan_next;
        last_reg       <= last_next;
        lo_mask_reg    <= lo_mask_next;
        hi_mask_reg    <= hi_mask_next;
        res_room_reg   <= res_room_next;
        res_status_reg <= res_status_next;
        out_room_reg   <= out_room_next;
        out_status_reg <= out_status_next;
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign granted_room = out_room_reg;
    assign status       = out_status_reg;

endmodule

// ===== test/tb_first_free_slot_allocator_core.sv =====
`timescale 1ns / 100ps

module tb_first_free_slot_allocator_core;
    import ffsa_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 12;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_ITEMS    = 75;
    localparam int SETTLE_CYCLES  = 40;
    localparam int DIRECTED_COUNT = 25;

    typedef logic [ROOM_W-1:0] room_t;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        room_t     value;
        logic      typed;
        room_t     exp_room;
        logic      exp_status;
    } directed_row_t;

    typedef struct packed {
        room_t room;
        logic  status;
    } grant_t;

    logic  clk;
    logic  rst_n;
    logic  cfg_valid;
    logic  cfg_ready;
    room_t room_count;
    logic  in_valid;
    logic  in_ready;
    room_t requested_room;
    logic  out_valid;
    logic  out_ready;
    room_t granted_room;
    logic  status;

    // Mirror of the block's configuration and occupancy bitmap.
    room_t room_cfg;
    bit    taken_map [1:NUM_ROOMS];

    grant_t pending_grants [$];
    int     error_count   = 0;
    int     cycle_count   = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;

    // Rows with typed set carry their expected result; the others take it from allocate_slot.
    localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{ROW_REQ, 11'd0,    1'b1, 11'd0,    STATUS_FULL},
        '{ROW_REQ, 11'd1,    1'b1, 11'd1,    STATUS_GRANTED},
        '{ROW_REQ, 11'd1,    1'b1, 11'd2,    STATUS_GRANTED},
        '{ROW_REQ, 11'd1024, 1'b1, 11'd1024, STATUS_GRANTED},
        '{ROW_REQ, 11'd1024, 1'b1, 11'd0,    STATUS_FULL},
        '{ROW_REQ, 11'd1025, 1'b1, 11'd0,    STATUS_FULL},
        '{ROW_REQ, 11'd2047, 1'b1, 11'd0,    STATUS_FULL},
        '{ROW_REQ, 11'd64,   1'b1, 11'd64,   STATUS_GRANTED},
        '{ROW_REQ, 11'd64,   1'b1, 11'd65,   STATUS_GRANTED},
        '{ROW_REQ, 11'd63,   1'b1, 11'd63,   STATUS_GRANTED},
        '{ROW_REQ, 11'd63,   1'b0, 11'd0,    STATUS_FULL},
        '{ROW_REQ, 11'd1,    1'b0, 11'd0,    STATUS_FULL},
        '{ROW_CFG, 11'd0,    1'b0, 11'd0,    STATUS_FULL},
        '{ROW_REQ, 11'd1,    1'b1, 11'd0,    STATUS_FULL},
        '{ROW_REQ, 11'd0,    1'b1, 11'd0,    STATUS_FULL},
        '{ROW_CFG, 11'd1,    1'b0, 11'd0,    STATUS_FULL},
        '{ROW_REQ, 11'd1,    1'b1, 11'd0,    STATUS_FULL},
        '{ROW_CFG, 11'd2047, 1'b0, 11'd0,    STATUS_FULL},
        '{ROW_REQ, 11'd1023, 1'b1, 11'd1023, STATUS_GRANTED},
        '{ROW_REQ, 11'd1022, 1'b1, 11'd1022, STATUS_GRANTED},
        '{ROW_REQ, 11'd1021, 1'b1, 11'd1021, STATUS_GRANTED},
        '{ROW_REQ, 11'd1021, 1'b1, 11'd0,    STATUS_FULL},
        '{ROW_CFG, 11'd3,    1'b0, 11'd0,    STATUS_FULL},
        '{ROW_REQ, 11'd2,    1'b0, 11'd0,    STATUS_FULL},
        '{ROW_REQ, 11'd4,    1'b1, 11'd0,    STATUS_FULL}
    };

    first_free_slot_allocator_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .room_count     (room_count),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .requested_room (requested_room),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .granted_room   (granted_room),
        .status         (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // Grants the lowest free slot from the request upwards, bounded by the room limit.
    function automatic grant_t allocate_slot(input room_t req);
        grant_t g;
        int     lim;
        g.room   = '0;
        g.status = STATUS_FULL;
        lim = (room_cfg > ROOM_LIMIT_MAX) ? NUM_ROOMS : int'(room_cfg);
        if (req != '0 && int'(req) <= lim)
        begin
            for (int s = int'(req); s <= lim && g.status == STATUS_FULL; s++)
            begin
                if (!taken_map[s])
                begin
                    taken_map[s] = 1'b1;
                    g.room       = room_t'(s);
                    g.status     = STATUS_GRANTED;
                end
            end
        end
        return g;
    endfunction

    task automatic send_request(input room_t req, input logic typed, input grant_t typed_grant);
        grant_t g;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        requested_room <= req;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        g = allocate_slot(req);
        pending_grants.insert(pending_grants.size(), typed ? typed_grant : g);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_grants.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_room_count(input room_t value);
        cfg_valid  <= 1'b1;
        room_count <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        room_cfg   = value;
    endtask

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        grant_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_grants.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual room %0d status %0b",
                         $time, granted_room, status);
                error_count++;
            end
            else
            begin
                want = pending_grants.pop_front();
                if (granted_room !== want.room)
                begin
                    $display("%0t: granted_room mismatch, expected %0d, actual %0d",
                             $time, want.room, granted_room);
                    error_count++;
                end
                if (status !== want.status)
                begin
                    $display("%0t: status mismatch, expected %0b, actual %0b",
                             $time, want.status, status);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        grant_t typed_grant;
        room_t  req;
        room_t  phase_cfg;
        int     lim;
        int     pick;
        rst_n          <= 1'b0;
        cfg_valid      <= 1'b0;
        room_count     <= '0;
        in_valid       <= 1'b0;
        requested_room <= '0;
        room_cfg        = ROOM_COUNT_RESET;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            if (DIRECTED_ROWS[i].kind == ROW_CFG)
            begin
                wait_for_results();
                write_room_count(DIRECTED_ROWS[i].value);
            end
            else
            begin
                typed_grant.room   = DIRECTED_ROWS[i].exp_room;
                typed_grant.status = DIRECTED_ROWS[i].exp_status;
                send_request(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].typed, typed_grant);
            end
        end

        typed_grant = '0;
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0: phase_cfg = 11'd2047;
                1: phase_cfg = ROOM_COUNT_RESET;
                2: phase_cfg = room_t'($urandom_range(64, 400));
                3: phase_cfg = room_t'($urandom_range(1, 1024));
                4: phase_cfg = ROOM_COUNT_RESET;
                5: phase_cfg = room_t'($urandom_range(1, 63));
                6: phase_cfg = 11'd2047;
                default: phase_cfg = room_t'($urandom_range(1, 2047));
            endcase
            wait_for_results();
            write_room_count(phase_cfg);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            lim = (room_cfg > ROOM_LIMIT_MAX) ? NUM_ROOMS : int'(room_cfg);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Low requests force long scans once the bottom of the map has filled.
                pick = $urandom_range(99);
                if (pick < 5)
                    req = '0;
                else if (pick < 12)
                    req = room_t'($urandom_range(0, 2047));
                else if (pick < 18 && lim < 2047)
                    req = room_t'($urandom_range(lim + 1, 2047));
                else if (pick < 40)
                    req = room_t'($urandom_range(1, lim / 8 + 1));
                else
                    req = room_t'($urandom_range(1, lim));
                send_request(req, 1'b0, typed_grant);
                if (n == 37 || $urandom_range(63) == 0)
                begin
                    wait_for_results();
                end
            end
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_grants.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
